// ===== hdl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants of the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int THR_WIDTH = 32;

    typedef struct packed {
        logic valid;
        logic singular;
    } t_ctl;

endpackage

// ===== hdl/matrix3x3_inverse_core.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// Inverse of one 3x3 signed fixed-point matrix per item by the adjugate.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_axis   in         tdata: a00 a01 a02 a10 a11 a12 a20 a21 a22
//  m_axis   out        tdata: b00 .. b22, tuser: singular, saturated
//  cfg      in         singular_threshold
//
// One item enters per cycle while the output is not stalled. Reset clears all
// valid bits and sets the threshold to one. A stall on the output freezes the
// whole pipeline.
module matrix3x3_inverse_core
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 from the lowest bit up.
    input  logic [((9 * ELEM_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // b00, b01, b02, b10, b11, b12, b20, b21, b22 from the lowest bit up.
    output logic [((9 * ELEM_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // singular, saturated from the lowest bit up.
    output logic [1:0]           m_axis_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [THR_WIDTH-1:0] i_cfg_data
);

    localparam int W   = ELEM_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int TDW = ((9 * ELEM_WIDTH + 7) / 8) * 8;
    localparam int DW  = 3 * W + 3;
    localparam int CMW = 2 * W;

    logic                 en;
    logic [THR_WIDTH-1:0] r_thr;
    t_ctl                 front_ctl;
    t_ctl                 r_ctl [W+1];
    logic [CMW-1:0]       cof_mag [9];
    logic [8:0]           cof_neg;
    logic [DW-1:0]        det_mag;
    logic [W-1:0]         quo [9];
    logic [8:0]           ovf;
    logic [8:0]           qneg;
    logic [W-1:0]         n_b [9];
    logic [8:0]           sat;
    logic [TDW-1:0]       n_data;
    logic                 r_out_valid;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_WIDTH'(1);
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    mi3_front #(.W(W), .F(F), .DW(DW), .CMW(CMW)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata[9*W-1:0]),
        .i_thr     (r_thr),
        .o_ctl     (front_ctl),
        .o_cof_mag (cof_mag),
        .o_cof_neg (cof_neg),
        .o_det_mag (det_mag)
    );

    genvar gk, gi, gj;
    generate
        for (gk = 0; gk < 9; gk++) begin : g_div
            mi3_div #(.W(W), .F(F), .DW(DW), .CMW(CMW)) u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (cof_mag[gk]),
                .i_neg (cof_neg[gk]),
                .i_den (det_mag),
                .o_quo (quo[gk]),
                .o_ovf (ovf[gk]),
                .o_neg (qneg[gk])
            );
            assign sat[gk] = ovf[gk] || (qneg[gk] ? (quo[gk][W-1] && (|quo[gk][W-2:0]))
                                                  : quo[gk][W-1]);
            assign n_b[gk] = sat[gk] ? {qneg[gk], {(W-1){!qneg[gk]}}}
                                     : (qneg[gk] ? W'(-quo[gk]) : quo[gk]);
        end
        for (gi = 0; gi < 3; gi++) begin : g_row
            for (gj = 0; gj < 3; gj++) begin : g_col
                assign n_data[(gj*3+gi)*W +: W] = r_ctl[W].singular ? '0 : n_b[gi*3+gj];
            end
        end
        if (TDW > 9 * W) begin : g_pad
            assign n_data[TDW-1:9*W] = '0;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= W; k++) begin
                r_ctl[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_ctl[0] <= front_ctl;
            for (int k = 1; k <= W; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
            r_out_valid <= r_ctl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata    <= n_data;
            m_axis_tuser[0] <= r_ctl[W].singular;
            m_axis_tuser[1] <= !r_ctl[W].singular && (|sat);
        end
    end

`ifndef NO_ASSERTIONS
    a_sing_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("Singular result is flagged as saturated.");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("Singular result carries nonzero elements.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");
`endif

endmodule

// ===== hdl/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front
// Cofactors, determinant by cofactor expansion and singularity test.
// ----------------------------------------------------------------------------
module mi3_front
    import mi3_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16,
    parameter int DW = 3 * W + 3,
    parameter int CMW = 2 * W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [9*W-1:0]       i_data,
    input  logic [THR_WIDTH-1:0] i_thr,
    output t_ctl                 o_ctl,
    output logic [CMW-1:0]       o_cof_mag [9],
    output logic [8:0]           o_cof_neg,
    output logic [DW-1:0]        o_det_mag
);

    logic signed [W-1:0]   a [9];
    logic signed [2*W-1:0] n_p1 [9];
    logic signed [2*W-1:0] n_p2 [9];
    logic signed [2*W-1:0] r_p1 [9];
    logic signed [2*W-1:0] r_p2 [9];
    logic signed [W-1:0]   r_a1 [3];
    logic signed [W-1:0]   r_a2 [3];
    logic signed [2*W:0]   r_c2 [9];
    logic signed [2*W:0]   r_c3 [9];
    logic signed [2*W:0]   r_c4 [9];
    logic signed [2*W:0]   n_lo [3];
    logic signed [2*W:0]   n_hi [3];
    logic signed [2*W:0]   r_lo [3];
    logic signed [2*W:0]   r_hi [3];
    logic signed [DW-1:0]  n_det;
    logic signed [DW-1:0]  r_det;
    logic [DW-1:0]         n_mag;
    logic                  n_sing;
    logic [CMW-1:0]        n_cm [9];
    logic [8:0]            n_cn;
    logic                  r_v1, r_v2, r_v3, r_v4;

    genvar gi, gj;
    generate
        for (gi = 0; gi < 9; gi++) begin : g_elem
            assign a[gi] = i_data[gi*W +: W];
        end
        for (gi = 0; gi < 3; gi++) begin : g_row
            for (gj = 0; gj < 3; gj++) begin : g_col
                localparam int I1 = (gi + 1) % 3;
                localparam int I2 = (gi + 2) % 3;
                localparam int J1 = (gj + 1) % 3;
                localparam int J2 = (gj + 2) % 3;
                assign n_p1[gi*3+gj] = a[I1*3+J1] * a[I2*3+J2];
                assign n_p2[gi*3+gj] = a[I1*3+J2] * a[I2*3+J1];
            end
        end
        for (gj = 0; gj < 3; gj++) begin : g_part
            assign n_lo[gj] = $signed({1'b0, r_c2[gj][W-1:0]}) * r_a2[gj];
            assign n_hi[gj] = $signed(r_c2[gj][2*W:W]) * r_a2[gj];
        end
    endgenerate

    always_comb begin
        n_det = '0;
        for (int k = 0; k < 3; k++) begin
            n_det = n_det + (DW'(r_hi[k]) <<< W) + DW'(r_lo[k]);
        end
    end

    always_comb begin
        n_mag  = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
        n_sing = (n_mag == '0) || ((n_mag >> (2 * F)) < DW'(i_thr));
        for (int k = 0; k < 9; k++) begin
            n_cm[k] = r_c4[k][2*W] ? CMW'(-r_c4[k]) : CMW'(r_c4[k]);
            n_cn[k] = r_c4[k][2*W] ^ r_det[DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            o_ctl <= '0;
        end else if (i_en) begin
            r_v1           <= i_valid;
            r_v2           <= r_v1;
            r_v3           <= r_v2;
            r_v4           <= r_v3;
            o_ctl.valid    <= r_v4;
            o_ctl.singular <= n_sing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_p1[k]      <= n_p1[k];
                r_p2[k]      <= n_p2[k];
                r_c2[k]      <= (2*W+1)'(r_p1[k]) - (2*W+1)'(r_p2[k]);
                r_c3[k]      <= r_c2[k];
                r_c4[k]      <= r_c3[k];
                o_cof_mag[k] <= n_cm[k];
            end
            for (int k = 0; k < 3; k++) begin
                r_a1[k] <= a[k];
                r_a2[k] <= r_a1[k];
                r_lo[k] <= n_lo[k];
                r_hi[k] <= n_hi[k];
            end
            r_det     <= n_det;
            o_cof_neg <= n_cn;
            o_det_mag <= n_mag;
        end
    end

endmodule

// ===== hdl/mi3_div.sv =====
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider, one quotient bit per stage, with overflow test.
// ----------------------------------------------------------------------------
module mi3_div
    import mi3_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16,
    parameter int DW = 3 * W + 3,
    parameter int CMW = 2 * W
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [CMW-1:0] i_num,
    input  logic           i_neg,
    input  logic [DW-1:0]  i_den,
    output logic [W-1:0]   o_quo,
    output logic           o_ovf,
    output logic           o_neg
);

    localparam int NW = CMW + 2 * F;
    localparam int XW = ((NW > DW + W) ? NW : DW + W) + 1;

    logic [XW-1:0] r_rem [W+1];
    logic [XW-1:0] r_den [W+1];
    logic [W-1:0]  r_quo [W+1];
    logic [W:0]    r_ovf;
    logic [W:0]    r_neg;
    logic [XW-1:0] n_rem0;

    assign n_rem0 = XW'(i_num) << (2 * F);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem0;
            r_den[0] <= XW'(i_den);
            r_quo[0] <= '0;
            r_ovf[0] <= n_rem0 >= (XW'(i_den) << W);
            r_neg[0] <= i_neg;
        end
    end

    genvar gs;
    generate
        for (gs = 1; gs <= W; gs++) begin : g_stage
            localparam int B = W - gs;
            logic [XW-1:0] sub_val;
            logic          take;
            assign sub_val = r_den[gs-1] << B;
            assign take    = r_rem[gs-1] >= sub_val;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[gs]    <= take ? r_rem[gs-1] - sub_val : r_rem[gs-1];
                    r_den[gs]    <= r_den[gs-1];
                    r_quo[gs]    <= r_quo[gs-1];
                    r_quo[gs][B] <= take;
                    r_ovf[gs]    <= r_ovf[gs-1];
                    r_neg[gs]    <= r_neg[gs-1];
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[W];
    assign o_ovf = r_ovf[W];
    assign o_neg = r_neg[W];

endmodule

// ===== dv/matrix3x3_inverse_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core_tb
// Streams 3x3 Q16.16 matrices into the inverse core and compares every
// returned inverse, with its singular and saturated flags, against an
// exact adjugate-based prediction kept in a small scoreboard.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core_tb;
    import mi3_pkg::*;

    localparam int FB   = 16;
    localparam int EW   = 32;
    localparam int TDW  = 9 * EW;
    localparam int LAT  = EW + 7;

    typedef logic signed [EW-1:0] t_elem;
    typedef struct packed {
        logic [1:0]     flags;
        logic [TDW-1:0] elems;
    } t_inverse;

    class inverse_scoreboard;
        t_inverse pending_inverses[$];
        logic [31:0] threshold = 32'd1;
        int errors = 0;
        int checked = 0;

        function t_inverse invert(logic [TDW-1:0] mat);
            logic signed [EW-1:0]  e [9];
            logic signed [127:0]   det, cof, mag, num, quo;
            logic signed [127:0]   lim;
            logic neg, sat;
            int i1, i2, j1, j2;
            t_inverse res;
            for (int k = 0; k < 9; k++) e[k] = mat[k*EW +: EW];
            det = 128'(e[0]) * e[4] * e[8] + 128'(e[1]) * e[5] * e[6]
                + 128'(e[2]) * e[3] * e[7] - 128'(e[0]) * e[5] * e[7]
                - 128'(e[1]) * e[3] * e[8] - 128'(e[2]) * e[4] * e[6];
            mag = det < 0 ? -det : det;
            res = '0;
            if (mag == 0 || (mag >>> (2*FB)) < $signed({96'd0, threshold})) begin
                res.flags = 2'b01;
                return res;
            end
            sat = 1'b0;
            lim = 128'sd1 <<< (EW - 1);
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    i1 = (i + 1) % 3; i2 = (i + 2) % 3;
                    j1 = (j + 1) % 3; j2 = (j + 2) % 3;
                    cof = 128'(e[i1*3+j1]) * e[i2*3+j2] - 128'(e[i1*3+j2]) * e[i2*3+j1];
                    neg = (cof < 0) ^ (det < 0);
                    num = (cof < 0 ? -cof : cof) <<< (2*FB);
                    quo = num / mag;
                    if (neg) begin
                        if (quo > lim) begin
                            sat = 1'b1;
                            quo = lim;
                        end
                        quo = -quo;
                    end else if (quo >= lim) begin
                        sat = 1'b1;
                        quo = lim - 1;
                    end
                    res.elems[(j*3+i)*EW +: EW] = quo[EW-1:0];
                end
            end
            res.flags = {sat, 1'b0};
            return res;
        endfunction

        function void note_matrix(logic [TDW-1:0] mat);
            pending_inverses.push_back(invert(mat));
        endfunction

        function void check_inverse(logic [TDW-1:0] data, logic [1:0] user);
            t_inverse exp_inv;
            checked++;
            if (pending_inverses.size() == 0) begin
                $display("%0t: unexpected result %h flags %b", $time, data, user);
                errors++;
                return;
            end
            exp_inv = pending_inverses.pop_front();
            for (int k = 0; k < 9; k++)
                if (data[k*EW +: EW] !== exp_inv.elems[k*EW +: EW]) begin
                    $display("%0t: b%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                             exp_inv.elems[k*EW +: EW], data[k*EW +: EW]);
                    errors++;
                end
            if (user[0] !== exp_inv.flags[0]) begin
                $display("%0t: singular expected %b actual %b", $time,
                         exp_inv.flags[0], user[0]);
                errors++;
            end
            if (user[1] !== exp_inv.flags[1]) begin
                $display("%0t: saturated expected %b actual %b", $time,
                         exp_inv.flags[1], user[1]);
                errors++;
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [TDW-1:0] s_axis_tdata = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [TDW-1:0] m_axis_tdata;
    logic [1:0]     m_axis_tuser;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [31:0]    i_cfg_data = '0;

    inverse_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    int  sent = 0;
    longint cycles = 0;
    int  sing_seen = 0;
    int  sat_seen = 0;

    always #4 i_clk = ~i_clk;

    matrix3x3_inverse_core #(.FRAC_BITS(FB), .ELEM_WIDTH(EW)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("matrix3x3_inverse_core_tb: errors");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_inverse(m_axis_tdata, m_axis_tuser);
            sing_seen += m_axis_tuser[0];
            sat_seen  += m_axis_tuser[1];
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    // The valid stays high after the accepting edge; the next item, an idle
    // cycle or the caller lowers it at the following falling edge.
    task automatic send_matrix(logic [TDW-1:0] mat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= mat;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_matrix(mat);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [31:0] value);
        while (sb.pending_inverses.size() != 0) @(negedge i_clk);
        repeat (LAT + 4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.threshold = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_elem rand_elem(int mode);
        case (mode)
            0: return t_elem'($urandom);
            1: return t_elem'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            2: return t_elem'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            default: return t_elem'($signed($urandom_range(0, 64)) - 32) <<< FB;
        endcase
    endfunction

    function automatic logic [TDW-1:0] rand_matrix();
        logic [TDW-1:0] m;
        int mode;
        mode = $urandom_range(3);
        for (int k = 0; k < 9; k++) m[k*EW +: EW] = rand_elem(mode);
        // Occasionally copy one row into another to force a singular case.
        if ($urandom_range(9) == 0) m[6*EW +: 3*EW] = m[3*EW +: 3*EW];
        return m;
    endfunction

    function automatic logic [TDW-1:0] diag(t_elem a, t_elem b, t_elem c);
        logic [TDW-1:0] m = '0;
        m[0 +: EW] = a; m[4*EW +: EW] = b; m[8*EW +: EW] = c;
        return m;
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) send_matrix(rand_matrix());
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        logic [TDW-1:0] m;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_matrix(diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        send_matrix(diag(32'sh0002_0000, -32'sh0004_0000, 32'sh0000_8000));
        send_matrix('0);
        send_matrix({9{32'h7FFF_FFFF}});
        send_matrix({9{32'h8000_0000}});
        send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag(32'sd1, 32'sd1, 32'sd1));
        send_matrix(diag(32'sh0000_0100, 32'sh0000_0100, 32'sh0000_0100));
        send_matrix(diag(-32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        send_matrix({9{32'hFFFF_FFFF}});
        m = '0;
        m[1*EW +: EW] = 32'sh0001_0000; m[3*EW +: EW] = 32'sh0001_0000;
        m[8*EW +: EW] = 32'sh0001_0000;
        send_matrix(m);
        s_axis_tvalid <= 1'b0;

        write_threshold(32'd0);
        send_matrix('0);
        send_matrix(diag(32'sd1, 32'sd1, 32'sd1));
        send_matrix(diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        s_axis_tvalid <= 1'b0;
        write_threshold(32'hFFFF_FFFF);
        send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_matrix(diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        s_axis_tvalid <= 1'b0;
        write_threshold(32'd1);

        send_idle_pct = 14; recv_idle_pct = 70;
        random_phase(450);
        write_threshold(32'd16);
        send_idle_pct = 70; recv_idle_pct = 14;
        random_phase(400);
        write_threshold(32'd0);
        send_idle_pct = 0; recv_idle_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(negedge i_clk);
                recv_hold = 1'b0;
            end
            random_phase(400);
        join
        write_threshold(32'd1);
        random_phase(400);

        while (sb.pending_inverses.size() != 0) @(negedge i_clk);
        repeat (LAT + 10) @(negedge i_clk);
        $display("Sent %0d matrices over four threshold settings, checked %0d inverses.",
                 sent, sb.checked);
        $display("Results flagged singular: %0d, saturated: %0d.", sing_seen, sat_seen);
        if (sb.errors == 0 && sb.pending_inverses.size() == 0)
            $display("matrix3x3_inverse_core_tb: clean");
        else
            $display("matrix3x3_inverse_core_tb: errors");
        $finish;
    end
endmodule
